FILE: rtl/power_alert_monitor_macros.svh
// Assertion macros shared by the power alert monitor checkers.
`ifndef POWER_ALERT_MONITOR_MACROS_SVH
`define POWER_ALERT_MONITOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PAM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pam_pkg.sv
// Shared types and constants of the power alert monitor.
`default_nettype none
package pam_pkg;

   localparam int SAMPLE_W = 16;
   localparam int POWER_W  = 32;
   localparam int TICK_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int LIMIT_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_MS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN_MS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POWER_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VOLTAGE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd4;

   // Register reset values.
   localparam logic [TICK_W-1:0]   RST_INTERVAL_MS   = 16'd1000;
   localparam logic [TICK_W-1:0]   RST_COOLDOWN_MS   = 16'd5000;
   localparam logic [POWER_W-1:0]  RST_POWER_LIMIT   = 32'd80000000;
   localparam logic [SAMPLE_W-1:0] RST_VOLTAGE_LIMIT = 16'd26000;
   localparam logic [SAMPLE_W-1:0] RST_CURRENT_LIMIT = 16'd15000;

   // Input item kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Limit alert codes.
   localparam logic [LIMIT_W-1:0] LIMIT_NONE    = 2'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_POWER   = 2'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_VOLTAGE = 2'd2;
   localparam logic [LIMIT_W-1:0] LIMIT_CURRENT = 2'd3;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

FILE: rtl/pam_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/pam_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit QUOT_W bits.
`default_nettype none
module pam_div #(
   parameter int QUOT_W = 16,
   parameter int DIVR_W = 13
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [QUOT_W+DIVR_W-1:0]   dividend,
   input  wire logic [DIVR_W-1:0]          divisor,
   output logic      [QUOT_W-1:0]          quotient,
   output pam_pkg::div_status_type         status
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [DIVR_W-1:0] rem_ff;
   logic [DIVR_W-1:0] rem_in;
   logic [QUOT_W-1:0] shift_ff;
   logic [DIVR_W-1:0] divisor_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   diff;
   logic              fits;

   // The upper dividend bits are already below the divisor, so only the
   // low QUOT_W bits need to be shifted through the remainder.
   always_comb begin
      trial  = {rem_ff, shift_ff[QUOT_W-1]};
      diff   = trial - {1'b0, divisor_ff};
      fits   = trial >= {1'b0, divisor_ff};
      rem_in = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         rem_ff     <= dividend[QUOT_W+DIVR_W-1:QUOT_W];
         shift_ff   <= dividend[QUOT_W-1:0];
         divisor_ff <= divisor;
         cnt_ff     <= CNT_W'(QUOT_W);
         busy_ff    <= 1'b1;
         done_ff    <= 1'b0;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= {shift_ff[QUOT_W-2:0], fits};
         cnt_ff   <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign quotient    = shift_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

FILE: rtl/power_alert_monitor.sv
// Power alert monitor top level: interval averaging, power ring and alert sequencer.
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | kind, volt_sample, amp_sample
//   rsp_    | out       | rsp_valid / rsp_stall  | means, power, spike and limit alerts
//   csr_    | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// Samples and ticks that close no interval are taken without stalling.
// A tick that closes an interval holding samples raises req_stall while one shared
// divider computes the voltage mean and then the current mean.
// The result waits in the output register while the next transaction is taken; only
// a finishing tick waits for that register to drain.
// Reset (synchronous) clears the sums, counters, ring fill and ring sum at once.
`default_nettype none
module power_alert_monitor #(
   parameter int RING_DEPTH  = 8,
   parameter int MAX_SAMPLES = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_kind,
   input  wire logic [pam_pkg::SAMPLE_W-1:0]     req_volt_sample,
   input  wire logic [pam_pkg::SAMPLE_W-1:0]     req_amp_sample,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [pam_pkg::SAMPLE_W-1:0]     rsp_mean_voltage,
   output logic      [pam_pkg::SAMPLE_W-1:0]     rsp_mean_current,
   output logic      [pam_pkg::POWER_W-1:0]      rsp_power,
   output logic                                  rsp_spike_alert,
   output logic      [pam_pkg::LIMIT_W-1:0]      rsp_limit_alert,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pam_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pam_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SW     = pam_pkg::SAMPLE_W;
   localparam int PWR_W  = pam_pkg::POWER_W;
   localparam int TW     = pam_pkg::TICK_W;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SW + CNT_W;
   localparam int POS_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int RSUM_W = PWR_W + POS_W;
   localparam int CMP_W  = RSUM_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VSTART,
      ST_VWAIT,
      ST_ISTART,
      ST_IWAIT,
      ST_MUL,
      ST_RING,
      ST_CMP
   } state_type;

   state_type state_ff;

   logic [TW-1:0]    interval_ms_ff;
   logic [TW-1:0]    cooldown_ms_ff;
   logic [PWR_W-1:0] power_limit_ff;
   logic [SW-1:0]    voltage_limit_ff;
   logic [SW-1:0]    current_limit_ff;

   logic [TW-1:0]     ticks_ff;
   logic [TW-1:0]     ticks_in;
   logic [TW-1:0]     since_ff;
   logic [TW-1:0]     since_in;
   logic [CNT_W-1:0]  total_ff;
   logic [SUM_W-1:0]  vsum_ff;
   logic [SUM_W-1:0]  isum_ff;
   logic [POS_W-1:0]  ring_pos_ff;
   logic [POS_W-1:0]  ring_pos_in;
   logic [FILL_W-1:0] fill_ff;
   logic [RSUM_W-1:0] rsum_ff;
   logic [RSUM_W-1:0] rsum_in;
   logic              ring_full;

   logic [SW-1:0]    mv_ff;
   logic [SW-1:0]    mi_ff;
   logic [PWR_W-1:0] pw_ff;
   logic [PWR_W-1:0] old_pw;
   logic [PWR_W-1:0] ram_rd_data;

   logic              alert_open;
   logic              spike_in;
   logic [pam_pkg::LIMIT_W-1:0] limit_in;
   logic [CMP_W-1:0]  spike_lhs;
   logic [CMP_W-1:0]  spike_rhs;

   logic                     rsp_valid_ff;
   logic [SW-1:0]            rsp_mv_ff;
   logic [SW-1:0]            rsp_mi_ff;
   logic [PWR_W-1:0]         rsp_pw_ff;
   logic                     rsp_spike_ff;
   logic [pam_pkg::LIMIT_W-1:0] rsp_limit_ff;

   logic                     div_start;
   logic [SUM_W-1:0]         div_dividend;
   logic [SW-1:0]            div_quotient;
   pam_pkg::div_status_type  div_status;

   // Shared divider: the voltage mean first, then the current mean.
   assign div_start    = ((state_ff == ST_VSTART) || (state_ff == ST_ISTART)) &&
                         !div_status.busy;
   assign div_dividend = (state_ff == ST_VSTART) ? vsum_ff : isum_ff;

   pam_div #(
      .QUOT_W (SW),
      .DIVR_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (total_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Power ring storage; the slot about to be overwritten is always being read.
   pam_ram #(
      .WIDTH (PWR_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock      (clock),
      .wr_en      (state_ff == ST_RING),
      .wr_addr    (ring_pos_ff),
      .wr_data    (pw_ff),
      .rd_addr    (ring_pos_ff),
      .rd_data_ff (ram_rd_data)
   );

   always_comb begin
      since_in    = (since_ff == '1) ? since_ff : since_ff + TW'(1);
      ticks_in    = (ticks_ff == '1) ? ticks_ff : ticks_ff + TW'(1);
      ring_full   = (fill_ff == FILL_W'(RING_DEPTH));
      // Until the ring has wrapped once, the slot being replaced still reads as zero.
      old_pw      = ring_full ? ram_rd_data : '0;
      rsum_in     = rsum_ff - RSUM_W'(old_pw) + RSUM_W'(pw_ff);
      ring_pos_in = (ring_pos_ff == POS_W'(RING_DEPTH - 1)) ? '0 : ring_pos_ff + POS_W'(1);

      alert_open = since_ff > cooldown_ms_ff;
      spike_lhs = CMP_W'(pw_ff) * CMP_W'(2 * RING_DEPTH);
      spike_rhs = (CMP_W'(rsum_ff) << 1) + CMP_W'(rsum_ff);
      spike_in  = alert_open && ring_full && (rsum_ff != '0) && (spike_lhs > spike_rhs);

      limit_in = pam_pkg::LIMIT_NONE;
      if (alert_open) begin
         priority if (pw_ff > power_limit_ff) begin
            limit_in = pam_pkg::LIMIT_POWER;
         end else if (mv_ff > voltage_limit_ff) begin
            limit_in = pam_pkg::LIMIT_VOLTAGE;
         end else if (mi_ff > current_limit_ff) begin
            limit_in = pam_pkg::LIMIT_CURRENT;
         end else begin
            limit_in = pam_pkg::LIMIT_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         interval_ms_ff   <= pam_pkg::RST_INTERVAL_MS;
         cooldown_ms_ff   <= pam_pkg::RST_COOLDOWN_MS;
         power_limit_ff   <= pam_pkg::RST_POWER_LIMIT;
         voltage_limit_ff <= pam_pkg::RST_VOLTAGE_LIMIT;
         current_limit_ff <= pam_pkg::RST_CURRENT_LIMIT;
         ticks_ff         <= '0;
         since_ff         <= '0;
         total_ff         <= '0;
         vsum_ff          <= '0;
         isum_ff          <= '0;
         ring_pos_ff      <= '0;
         fill_ff          <= '0;
         rsum_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // In the result state the output register is handled below.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_CMP)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid) begin
            unique case (csr_index)
               pam_pkg::REG_INTERVAL_MS:   interval_ms_ff   <= csr_wdata[TW-1:0];
               pam_pkg::REG_COOLDOWN_MS:   cooldown_ms_ff   <= csr_wdata[TW-1:0];
               pam_pkg::REG_POWER_LIMIT:   power_limit_ff   <= csr_wdata[PWR_W-1:0];
               pam_pkg::REG_VOLTAGE_LIMIT: voltage_limit_ff <= csr_wdata[SW-1:0];
               pam_pkg::REG_CURRENT_LIMIT: current_limit_ff <= csr_wdata[SW-1:0];
               default: begin
               end
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_kind == pam_pkg::KIND_SAMPLE) begin
                     if (total_ff < CNT_W'(MAX_SAMPLES)) begin
                        vsum_ff  <= vsum_ff + SUM_W'(req_volt_sample);
                        isum_ff  <= isum_ff + SUM_W'(req_amp_sample);
                        total_ff <= total_ff + CNT_W'(1);
                     end
                  end else begin
                     since_ff <= since_in;
                     if (ticks_in >= interval_ms_ff) begin
                        if (total_ff == '0) begin
                           ticks_ff <= '0;
                           vsum_ff  <= '0;
                           isum_ff  <= '0;
                        end else begin
                           ticks_ff <= ticks_in;
                           state_ff <= ST_VSTART;
                        end
                     end else begin
                        ticks_ff <= ticks_in;
                     end
                  end
               end
            end
            ST_VSTART: begin
               if (div_start) begin
                  state_ff <= ST_VWAIT;
               end
            end
            ST_VWAIT: begin
               if (div_status.done) begin
                  mv_ff    <= div_quotient;
                  state_ff <= ST_ISTART;
               end
            end
            ST_ISTART: begin
               if (div_start) begin
                  state_ff <= ST_IWAIT;
               end
            end
            ST_IWAIT: begin
               if (div_status.done) begin
                  mi_ff    <= div_quotient;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               pw_ff    <= PWR_W'(mv_ff) * PWR_W'(mi_ff);
               ticks_ff <= '0;
               total_ff <= '0;
               vsum_ff  <= '0;
               isum_ff  <= '0;
               state_ff <= ST_RING;
            end
            ST_RING: begin
               rsum_ff     <= rsum_in;
               ring_pos_ff <= ring_pos_in;
               if (!ring_full) begin
                  fill_ff <= fill_ff + FILL_W'(1);
               end
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mv_ff    <= mv_ff;
                  rsp_mi_ff    <= mi_ff;
                  rsp_pw_ff    <= pw_ff;
                  rsp_spike_ff <= spike_in;
                  rsp_limit_ff <= limit_in;
                  if (spike_in || (limit_in != pam_pkg::LIMIT_NONE)) begin
                     since_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_voltage = rsp_mv_ff;
   assign rsp_mean_current = rsp_mi_ff;
   assign rsp_power        = rsp_pw_ff;
   assign rsp_spike_alert  = rsp_spike_ff;
   assign rsp_limit_alert  = rsp_limit_ff;

endmodule
`default_nettype wire

FILE: rtl/pam_checker.sv
// Port-level checker for the power alert monitor, bound to the top level.
`default_nettype none
`include "power_alert_monitor_macros.svh"
module pam_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             req_kind,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [pam_pkg::SAMPLE_W-1:0]     rsp_mean_voltage,
   input wire logic [pam_pkg::SAMPLE_W-1:0]     rsp_mean_current,
   input wire logic [pam_pkg::POWER_W-1:0]      rsp_power,
   input wire logic                             rsp_spike_alert,
   input wire logic [pam_pkg::LIMIT_W-1:0]      rsp_limit_alert
);

   // A stalled result transaction keeps its power and alert payload.
   `PAM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_power) && $stable(rsp_limit_alert) && $stable(rsp_spike_alert), "stalled result changed")

   // A sample transaction never holds off the next one.
   `PAM_ASSERT_NEXT(a_sample_fast, req_valid && !req_stall && (req_kind == pam_pkg::KIND_SAMPLE), !req_stall, "sample transaction stalled the input")

   // A new result only appears after the interval sequencer has been busy.
   `PAM_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), $past(req_stall), "result appeared without interval processing")

   // Power is always the product of the two means.
   `PAM_ASSERT_NOW(a_power_product, rsp_valid, rsp_power == 32'(rsp_mean_voltage) * 32'(rsp_mean_current), "power differs from product of means")

endmodule

bind power_alert_monitor pam_checker u_pam_checker (.*);
`default_nettype wire
